>>> rtl/dbp_pkg.sv
// Shared types and constants for the directory entry block parser.
package dbp_pkg;

    localparam int MAX_BLOCK_BYTES = 65536;
    localparam int HDR_BYTES       = 8;
    localparam int OFF_W           = 17;
    localparam int ADDR_W          = 3;

    localparam logic [OFF_W-1:0] BLOCK_SIZE_RESET = OFF_W'(4096);
    localparam logic [7:0]       TAIL_TYPE_RESET  = 8'd222;

    typedef enum logic [ADDR_W-3:0] {
        REG_BLOCK_SIZE = 1'b0,
        REG_TAIL_TYPE  = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] entry_inode;
        logic [7:0]  entry_type;
        logic [7:0]  entry_name_length;
        logic [7:0]  name_char;
        logic [7:0]  name_position;
        logic        name_final;
        logic        block_good;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

    typedef struct packed {
        logic [OFF_W-1:0] block_bytes;
        logic [7:0]       tail_type_code;
    } cfg_t;

endpackage

>>> rtl/dbp_if.sv
// Valid/ready channel interfaces for input bytes and parse results.
interface dbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface dbp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] entry_inode;
    logic [7:0]  entry_type;
    logic [7:0]  entry_name_length;
    logic [7:0]  name_char;
    logic [7:0]  name_position;
    logic        name_final;
    logic        block_good;
    logic        last_of_run;

    modport source (
        output valid, output kind, output entry_inode, output entry_type,
        output entry_name_length, output name_char, output name_position,
        output name_final, output block_good, output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input entry_inode, input entry_type,
        input entry_name_length, input name_char, input name_position,
        input name_final, input block_good, input last_of_run, output ready
    );
endinterface

>>> rtl/dbp_cfg.sv
// APB configuration registers: block size and checksum tail type code.
module dbp_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dbp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output dbp_pkg::cfg_t              cfg
);

    logic [dbp_pkg::OFF_W-1:0] block_bytes_reg;
    logic [7:0]                tail_type_reg;
    logic                      wr_en;
    dbp_pkg::reg_index_t       idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = dbp_pkg::reg_index_t'(paddr[dbp_pkg::ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= dbp_pkg::BLOCK_SIZE_RESET;
            tail_type_reg   <= dbp_pkg::TAIL_TYPE_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                dbp_pkg::REG_BLOCK_SIZE: block_bytes_reg <= pwdata[dbp_pkg::OFF_W-1:0];
                dbp_pkg::REG_TAIL_TYPE:  tail_type_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            dbp_pkg::REG_BLOCK_SIZE: prdata = {15'd0, block_bytes_reg};
            dbp_pkg::REG_TAIL_TYPE:  prdata = {24'd0, tail_type_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.block_bytes    = block_bytes_reg;
    assign cfg.tail_type_code = tail_type_reg;

endmodule

>>> rtl/dbp_parse.sv
// Per-byte parse state and result generation for one accepted byte.
module dbp_parse (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [7:0]     data_byte,
    input  dbp_pkg::cfg_t  cfg,
    output dbp_pkg::push_t push
);

    localparam logic [3:0] PH_TYPE = 4'd7;
    localparam logic [3:0] PH_BODY = 4'd8;
    localparam logic [3:0] PH_SKIP = 4'd9;
    localparam int         OW      = dbp_pkg::OFF_W;

    logic [OW-1:0] offset_reg, offset_next;
    logic [OW-1:0] start_reg, start_next;
    logic [3:0]    phase_reg, phase_next;
    logic [31:0]   inode_reg, inode_next;
    logic [15:0]   rec_len_reg, rec_len_next;
    logic [7:0]    name_len_reg, name_len_next;
    logic [7:0]    type_reg, type_next;
    logic          live_reg, live_next;
    logic          failed_reg, failed_next;

    logic [OW-1:0] bs;
    logic [OW:0]   off_inc;
    logic [OW:0]   start_ext;
    logic [OW+1:0] body_pos;
    logic          bad;
    logic          live_now;
    logic          emit_err;
    logic          emit_name;
    logic          block_end;
    dbp_pkg::result_t err_res, name_res, end_res;

    // Clamp the configured size to the supported range.
    always_comb
    begin
        if (cfg.block_bytes < OW'(dbp_pkg::HDR_BYTES))
            bs = OW'(dbp_pkg::HDR_BYTES);
        else if (cfg.block_bytes > OW'(dbp_pkg::MAX_BLOCK_BYTES))
            bs = OW'(dbp_pkg::MAX_BLOCK_BYTES);
        else
            bs = cfg.block_bytes;
    end

    assign off_inc   = {1'b0, offset_reg} + (OW+1)'(1);
    assign start_ext = {1'b0, start_reg};
    assign body_pos  = {2'b00, offset_reg} - {2'b00, start_reg} - (OW+2)'(dbp_pkg::HDR_BYTES);
    assign block_end = off_inc >= {1'b0, bs};

    always_comb
    begin
        offset_next   = offset_reg;
        start_next    = start_reg;
        phase_next    = phase_reg;
        inode_next    = inode_reg;
        rec_len_next  = rec_len_reg;
        name_len_next = name_len_reg;
        type_next     = type_reg;
        live_next     = live_reg;
        failed_next   = failed_reg;
        emit_err      = 1'b0;
        emit_name     = 1'b0;
        bad           = 1'b0;
        live_now      = 1'b0;

        if (!failed_reg)
        begin
            if (phase_reg < PH_BODY)
            begin
                if (phase_reg == 4'd0 &&
                    (start_ext + (OW+1)'(dbp_pkg::HDR_BYTES)) > {1'b0, bs})
                begin
                    phase_next = PH_SKIP;
                end
                else
                begin
                    case (phase_reg)
                        4'd0, 4'd1, 4'd2, 4'd3:
                            inode_next[{phase_reg[1:0], 3'b000} +: 8] = data_byte;
                        4'd4:    rec_len_next[7:0]  = data_byte;
                        4'd5:    rec_len_next[15:8] = data_byte;
                        4'd6:    name_len_next      = data_byte;
                        default: type_next          = data_byte;
                    endcase
                    if (phase_reg != PH_TYPE)
                    begin
                        phase_next = phase_reg + 4'd1;
                    end
                    else
                    begin
                        live_now = (inode_reg != 32'd0) && (name_len_reg != 8'd0) &&
                                   (data_byte != cfg.tail_type_code);
                        bad = (rec_len_reg < 16'(dbp_pkg::HDR_BYTES)) ||
                              (rec_len_reg[1:0] != 2'b00) ||
                              ((start_ext + (OW+1)'(rec_len_reg)) > {1'b0, bs}) ||
                              (live_now && (9'(dbp_pkg::HDR_BYTES) + 9'(name_len_reg) >
                                            9'(rec_len_reg)) &&
                               (rec_len_reg[15:9] == 7'd0));
                        live_next = live_now;
                        if (bad)
                        begin
                            failed_next = 1'b1;
                            live_next   = 1'b0;
                            emit_err    = 1'b1;
                        end
                        else if (rec_len_reg == 16'(dbp_pkg::HDR_BYTES))
                        begin
                            start_next = off_inc[OW-1:0];
                            phase_next = 4'd0;
                            live_next  = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
            end
            else if (phase_reg == PH_BODY)
            begin
                emit_name = live_reg && !body_pos[OW+1] &&
                            (body_pos < (OW+2)'(name_len_reg));
                if (off_inc >= start_ext + (OW+1)'(rec_len_reg))
                begin
                    start_next = off_inc[OW-1:0];
                    phase_next = 4'd0;
                    live_next  = 1'b0;
                end
            end
        end

        if (block_end)
        begin
            // End of block: drop all entry state.
            offset_next   = '0;
            start_next    = '0;
            phase_next    = 4'd0;
            inode_next    = 32'd0;
            rec_len_next  = 16'd0;
            name_len_next = 8'd0;
            type_next     = 8'd0;
            live_next     = 1'b0;
            failed_next   = 1'b0;
        end
        else
        begin
            offset_next = off_inc[OW-1:0];
        end
    end

    always_comb
    begin
        err_res             = '0;
        err_res.kind        = dbp_pkg::KIND_ERROR;
        err_res.last_of_run = !block_end;

        name_res                   = '0;
        name_res.kind              = dbp_pkg::KIND_NAME;
        name_res.entry_inode       = inode_reg;
        name_res.entry_type        = type_reg;
        name_res.entry_name_length = name_len_reg;
        name_res.name_char         = data_byte;
        name_res.name_position     = body_pos[7:0];
        name_res.name_final        = (body_pos[7:0] + 8'd1) == name_len_reg;
        name_res.last_of_run       = !block_end;

        end_res             = '0;
        end_res.kind        = dbp_pkg::KIND_END;
        end_res.block_good  = !(failed_reg || emit_err);
        end_res.last_of_run = 1'b1;
    end

    // Pack up to two results: the entry result first, then the end result.
    always_comb
    begin
        push.push0 = 1'b0;
        push.push1 = 1'b0;
        push.res0  = end_res;
        push.res1  = end_res;
        if (in_fire)
        begin
            if (emit_err || emit_name)
            begin
                push.push0 = 1'b1;
                push.res0  = emit_err ? err_res : name_res;
                push.push1 = block_end;
            end
            else
            begin
                push.push0 = block_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            start_reg    <= '0;
            phase_reg    <= 4'd0;
            inode_reg    <= 32'd0;
            rec_len_reg  <= 16'd0;
            name_len_reg <= 8'd0;
            type_reg     <= 8'd0;
            live_reg     <= 1'b0;
            failed_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            offset_reg   <= offset_next;
            start_reg    <= start_next;
            phase_reg    <= phase_next;
            inode_reg    <= inode_next;
            rec_len_reg  <= rec_len_next;
            name_len_reg <= name_len_next;
            type_reg     <= type_next;
            live_reg     <= live_next;
            failed_reg   <= failed_next;
        end
    end

endmodule

>>> rtl/dbp_outq.sv
// Four-entry result queue: takes up to two results a cycle, hands out one.
module dbp_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  dbp_pkg::push_t    push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output dbp_pkg::result_t  out_res
);

    dbp_pkg::result_t entry_reg [4];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] tail_plus1;

    assign room       = count_reg < 3'd3;
    assign out_valid  = count_reg != 3'd0;
    assign out_res    = entry_reg[head_reg];
    assign pop        = out_valid & out_ready;
    assign tail_plus1 = tail_reg + 2'd1;

    always_comb
    begin
        head_next  = head_reg + {1'b0, pop};
        tail_next  = tail_reg + {1'b0, push.push0} + {1'b0, push.push1};
        count_next = count_reg + {2'b00, push.push0} + {2'b00, push.push1} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry_reg[tail_reg] <= push.res0;
        end
        if (push.push1)
        begin
            entry_reg[tail_plus1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/dir_entry_block_parser_core.sv
// Directory entry block parser: top level with byte, result and APB ports.
//
// in_ch carries one byte of a directory block per item, from offset zero.
// out_ch carries results: name bytes of live entries with their header
// fields, one format error item per bad block, and an end-of-block item with
// the block status. A byte yields zero, one or two results (two only when
// the last byte of a block also produces a name byte or an error).
// A result is written into the result queue registers when its byte is taken.
// Throughput: one byte per cycle while the queue has room; the parse update
// is a single pass of offset adds and compares between the byte handshake
// and the result queue. A four-entry result queue sits between the two
// sides, so the block keeps taking bytes while results wait; in_ch.ready
// drops only when fewer than two queue slots are free, until out_ch drains.
// Reset clears the parse state to the start of a block, empties the queue,
// and sets block_bytes to 4096 and tail_type_code to 222.
// The APB registers sit at byte address 0 (block_bytes) and 4
// (tail_type_code); write them only while no byte is in flight.
module dir_entry_block_parser_core (
    input  logic                       clk,
    input  logic                       rst_n,
    dbp_byte_if.sink                   in_ch,
    dbp_result_if.source               out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dbp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    dbp_pkg::cfg_t    cfg;
    dbp_pkg::push_t   push;
    dbp_pkg::result_t head_res;
    logic             room;
    logic             in_fire;

    assign in_ch.ready = room;
    assign in_fire     = in_ch.valid & room;

    dbp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dbp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (in_ch.data_byte),
        .cfg       (cfg),
        .push      (push)
    );

    dbp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (head_res)
    );

    assign out_ch.kind              = head_res.kind;
    assign out_ch.entry_inode       = head_res.entry_inode;
    assign out_ch.entry_type        = head_res.entry_type;
    assign out_ch.entry_name_length = head_res.entry_name_length;
    assign out_ch.name_char         = head_res.name_char;
    assign out_ch.name_position     = head_res.name_position;
    assign out_ch.name_final        = head_res.name_final;
    assign out_ch.block_good        = head_res.block_good;
    assign out_ch.last_of_run       = head_res.last_of_run;

endmodule

>>> tb/sv/dir_entry_block_parser_core_tb.sv
// Self-checking testbench for the directory entry block parser core.
module dir_entry_block_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_BODY  = 8;
    localparam int PHASE_SKIP  = 9;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 40;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [dbp_pkg::ADDR_W-1:0]  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    dbp_byte_if   byte_ch ();
    dbp_result_if result_ch ();

    dir_entry_block_parser_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (byte_ch),
        .out_ch  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Parser shadow state and register copies
    logic [dbp_pkg::OFF_W-1:0] blk_size_reg  = dbp_pkg::BLOCK_SIZE_RESET;
    logic [7:0]                tail_code_reg = dbp_pkg::TAIL_TYPE_RESET;
    int unsigned      cur_offset    = 0;
    int unsigned      entry_base    = 0;
    int unsigned      hdr_phase     = 0;
    logic [31:0]      hdr_inode     = '0;
    logic [15:0]      hdr_rec_len   = '0;
    logic [7:0]       hdr_name_len  = '0;
    logic [7:0]       hdr_type      = '0;
    logic             entry_is_live = 1'b0;
    logic             blk_failed    = 1'b0;

    dbp_pkg::result_t pending_results[$];
    logic [7:0]  block_q[$];
    int          mismatches   = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    logic        hold_req     = 1'b0;
    int          stall_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    function automatic int unsigned clamp_size(input logic [dbp_pkg::OFF_W-1:0] raw);
        if (raw < dbp_pkg::HDR_BYTES)
            return dbp_pkg::HDR_BYTES;
        if (raw > dbp_pkg::MAX_BLOCK_BYTES)
            return dbp_pkg::MAX_BLOCK_BYTES;
        return 32'(raw);
    endfunction

    function automatic dbp_pkg::result_t make_result(input dbp_pkg::kind_t k,
                                                     input logic [31:0] ino,
                                                     input logic [7:0] ty, input logic [7:0] nl,
                                                     input logic [7:0] ch, input logic [7:0] pos,
                                                     input logic fin, input logic good);
        dbp_pkg::result_t r;
        r.kind              = k;
        r.entry_inode       = ino;
        r.entry_type        = ty;
        r.entry_name_length = nl;
        r.name_char         = ch;
        r.name_position     = pos;
        r.name_final        = fin;
        r.block_good        = good;
        r.last_of_run       = 1'b0;
        return r;
    endfunction

    // Advance the shadow parser by one accepted byte and queue its results
    task automatic advance_parser(input logic [7:0] b);
        int unsigned bs;
        int unsigned off;
        int unsigned rl;
        int unsigned pos;
        int          n_before;
        logic        bad;
        dbp_pkg::result_t r;
        bs       = clamp_size(blk_size_reg);
        off      = cur_offset;
        n_before = pending_results.size();
        if (!blk_failed)
        begin
            if (hdr_phase < dbp_pkg::HDR_BYTES)
            begin
                if (hdr_phase == 0 && entry_base + dbp_pkg::HDR_BYTES > bs)
                    hdr_phase = PHASE_SKIP;
                else
                begin
                    if (hdr_phase < 4)
                        hdr_inode[8*hdr_phase +: 8] = b;
                    else if (hdr_phase == 4)
                        hdr_rec_len[7:0] = b;
                    else if (hdr_phase == 5)
                        hdr_rec_len[15:8] = b;
                    else if (hdr_phase == 6)
                        hdr_name_len = b;
                    else
                        hdr_type = b;
                    if (hdr_phase < 7)
                        hdr_phase++;
                    else
                    begin
                        rl  = hdr_rec_len;
                        bad = rl < dbp_pkg::HDR_BYTES || rl[1:0] != 2'b00 ||
                              entry_base + rl > bs;
                        entry_is_live = hdr_inode != 0 && hdr_name_len != 0 &&
                                        hdr_type != tail_code_reg;
                        if (!bad && entry_is_live && dbp_pkg::HDR_BYTES + hdr_name_len > rl)
                            bad = 1'b1;
                        if (bad)
                        begin
                            blk_failed    = 1'b1;
                            entry_is_live = 1'b0;
                            pending_results.push_back(
                                make_result(dbp_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 1'b0, 1'b0));
                        end
                        else if (rl == dbp_pkg::HDR_BYTES)
                        begin
                            entry_base    = off + 1;
                            hdr_phase     = 0;
                            entry_is_live = 1'b0;
                        end
                        else
                            hdr_phase = PHASE_BODY;
                    end
                end
            end
            else if (hdr_phase == PHASE_BODY)
            begin
                pos = off - entry_base - dbp_pkg::HDR_BYTES;
                if (entry_is_live && off >= entry_base + dbp_pkg::HDR_BYTES &&
                    pos < hdr_name_len)
                    pending_results.push_back(
                        make_result(dbp_pkg::KIND_NAME, hdr_inode, hdr_type, hdr_name_len,
                                    b, pos[7:0], pos + 1 == hdr_name_len, 1'b0));
                if (off + 1 >= entry_base + hdr_rec_len)
                begin
                    entry_base    = off + 1;
                    hdr_phase     = 0;
                    entry_is_live = 1'b0;
                end
            end
        end
        if (off + 1 >= bs)
        begin
            pending_results.push_back(
                make_result(dbp_pkg::KIND_END, 0, 0, 0, 0, 0, 1'b0, !blk_failed));
            cur_offset    = 0;
            entry_base    = 0;
            hdr_phase     = 0;
            hdr_inode     = '0;
            hdr_rec_len   = '0;
            hdr_name_len  = '0;
            hdr_type      = '0;
            entry_is_live = 1'b0;
            blk_failed    = 1'b0;
        end
        else
            cur_offset = off + 1;
        // mark the last result of this byte
        if (pending_results.size() > n_before)
        begin
            r             = pending_results.pop_back();
            r.last_of_run = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        advance_parser(b);
    endtask

    task automatic send_block(input int n);
        for (int i = 0; i < n; i++)
            send_byte(block_q[i]);
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input dbp_pkg::reg_index_t idx, input logic [31:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == dbp_pkg::REG_BLOCK_SIZE)
            blk_size_reg = value[dbp_pkg::OFF_W-1:0];
        else
            tail_code_reg = value[7:0];
        @(posedge clk);
    endtask

    task automatic read_reg(input dbp_pkg::reg_index_t idx, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void add_header(input logic [31:0] ino, input logic [15:0] rl,
                                       input logic [7:0] nl, input logic [7:0] ty);
        for (int i = 0; i < 4; i++)
            block_q.push_back(ino[8*i +: 8]);
        block_q.push_back(rl[7:0]);
        block_q.push_back(rl[15:8]);
        block_q.push_back(nl);
        block_q.push_back(ty);
    endfunction

    function automatic void add_entry(input logic [31:0] ino, input logic [15:0] rl,
                                      input logic [7:0] nl, input logic [7:0] ty);
        add_header(ino, rl, nl, ty);
        for (int i = dbp_pkg::HDR_BYTES; i < rl; i++)
            block_q.push_back($urandom_range(255));
    endfunction

    function automatic void pad_block(input int unsigned n);
        while (block_q.size() < n)
            block_q.push_back($urandom_range(255));
        while (block_q.size() > n)
            void'(block_q.pop_back());
    endfunction

    // Mostly well-formed entries, some with a damaged header, some pure noise
    function automatic void build_random_block(input int unsigned bs);
        int unsigned off;
        int unsigned maxrl;
        int unsigned minrl;
        int unsigned nl;
        int unsigned rl;
        int unsigned sel;
        int unsigned mode;
        int unsigned steps;
        logic [31:0] ino;
        logic [7:0]  ty;
        int unsigned hdrs[$];
        block_q.delete();
        mode = $urandom_range(99);
        off  = 0;
        if (mode >= 10)
        begin
            while (bs - off >= dbp_pkg::HDR_BYTES)
            begin
                maxrl = (bs - off) & ~32'd3;
                sel   = $urandom_range(9);
                ino   = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
                if (ino == 0)
                    ino = 1;
                ty = $urandom_range(255);
                if (ty == tail_code_reg)
                    ty = ty ^ 8'h01;
                nl    = 0;
                minrl = dbp_pkg::HDR_BYTES;
                if (sel <= 5 && maxrl > dbp_pkg::HDR_BYTES)
                begin
                    nl    = $urandom_range((maxrl - dbp_pkg::HDR_BYTES > 255) ? 255 :
                                           maxrl - dbp_pkg::HDR_BYTES, 1);
                    minrl = (dbp_pkg::HDR_BYTES + nl + 3) & ~32'd3;
                end
                else if (sel == 6)
                begin
                    ino = 0;
                    nl  = $urandom_range(255);
                end
                else if (sel == 8)
                begin
                    ty = tail_code_reg;
                    nl = $urandom_range(255);
                end
                if (sel == 9)
                    rl = dbp_pkg::HDR_BYTES;
                else if ($urandom_range(3) == 0)
                    rl = maxrl;
                else
                begin
                    steps = (maxrl - minrl) / 4;
                    rl    = minrl + 4 * $urandom_range((steps > 3) ? 3 : steps);
                end
                hdrs.push_back(off);
                add_entry(ino, rl[15:0], nl[7:0], ty);
                off += rl;
            end
        end
        pad_block(bs);
        // damage a length or type byte of one header
        if (mode >= 10 && mode < 30 && hdrs.size() > 0)
            block_q[hdrs[$urandom_range(hdrs.size() - 1)] + $urandom_range(7, 4)] =
                $urandom_range(255);
    endfunction

    // Feed filler bytes until the shadow parser is back at a block start
    task automatic finish_block();
        while (cur_offset != 0)
            send_byte($urandom_range(255));
    endtask

    task automatic test_register_access();
        logic [31:0] value;
        read_reg(dbp_pkg::REG_BLOCK_SIZE, value);
        check_field("block_bytes reset", value, 32'(dbp_pkg::BLOCK_SIZE_RESET));
        read_reg(dbp_pkg::REG_TAIL_TYPE, value);
        check_field("tail_type_code reset", value, 32'(dbp_pkg::TAIL_TYPE_RESET));
        write_reg(dbp_pkg::REG_TAIL_TYPE, 32'hFFFF_FF5A);
        read_reg(dbp_pkg::REG_TAIL_TYPE, value);
        check_field("tail_type_code", value, 32'h5A);
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'hFFFF_ABCD);
        read_reg(dbp_pkg::REG_BLOCK_SIZE, value);
        check_field("block_bytes", value, 32'h1_ABCD);
    endtask

    // Live, dead, nameless, tail and header-only entries; last name ends the block
    task automatic test_entry_kinds();
        write_reg(dbp_pkg::REG_TAIL_TYPE, 32'd222);
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd512);
        block_q.delete();
        add_entry(32'hFFFF_FFFF, 264, 255, 255);
        add_entry(1, 12, 1, 0);
        add_entry(0, 12, 3, 1);
        add_entry(5, 12, 0, 2);
        add_entry(6, 16, 4, tail_code_reg);
        add_entry(8, 8, 0, 1);
        add_entry(32'h8000_0000, 188, 180, 8'h7F);
        send_block(block_q.size());
    endtask

    task automatic test_format_errors();
        int unsigned bad_rl[5]  = '{6, 10, 36, 12, 0};
        int unsigned bad_nl[5]  = '{1, 1, 1, 9, 1};
        int unsigned bad_ino[5] = '{7, 7, 7, 9, 0};
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd32);
        for (int i = 0; i < 5; i++)
        begin
            block_q.delete();
            add_header(bad_ino[i], bad_rl[i][15:0], bad_nl[i][7:0], 8'd1);
            pad_block(32);
            send_block(block_q.size());
        end
    endtask

    // Dead entry with an oversized name, then a remainder too short for a header
    task automatic test_short_remainder();
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd30);
        block_q.delete();
        add_entry(3, 12, 4, 1);
        add_entry(0, 12, 200, 1);
        pad_block(30);
        send_block(block_q.size());
    endtask

    task automatic test_smallest_block();
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd0);
        block_q.delete();
        add_header(4, 8, 1, 1);
        add_header(4, 8, 0, 1);
        send_block(block_q.size());
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd5);
        block_q.delete();
        add_header(0, 8, 7, 1);
        add_header(4, 12, 1, 1);
        send_block(block_q.size());
    endtask

    task automatic test_size_change_mid_block();
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd64);
        block_q.delete();
        add_entry(2, 24, 10, 1);
        add_entry(3, 40, 30, 1);
        send_block(40);
        // offset already past the new size: next byte closes the block
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd32);
        send_block(3);
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd128);
        finish_block();
    endtask

    task automatic test_backpressure();
        write_reg(dbp_pkg::REG_TAIL_TYPE, 32'd222);
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd256);
        block_q.delete();
        add_entry(11, 128, 120, 3);
        add_entry(12, 128, 120, 4);
        hold_req = 1'b1;
        send_block(block_q.size());
    endtask

    task automatic test_random_blocks(input int n_bytes);
        int                        sent;
        int unsigned               pick;
        logic [dbp_pkg::OFF_W-1:0] raw;
        logic [31:0]               junk;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(3))
                    0:       write_reg(dbp_pkg::REG_TAIL_TYPE, 32'd0);
                    1:       write_reg(dbp_pkg::REG_TAIL_TYPE, 32'd255);
                    2:       write_reg(dbp_pkg::REG_TAIL_TYPE, 32'd222);
                    default: write_reg(dbp_pkg::REG_TAIL_TYPE, $urandom);
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 5)
                raw = $urandom_range(7);
            else if (pick < 75)
                raw = $urandom_range(96, 8);
            else if (pick < 95)
                raw = $urandom_range(300, 97);
            else
                raw = $urandom_range(600, 301);
            junk = $urandom;
            write_reg(dbp_pkg::REG_BLOCK_SIZE, {junk[31:dbp_pkg::OFF_W], raw});
            build_random_block(clamp_size(raw));
            send_block(block_q.size());
            sent += block_q.size();
        end
    endtask

    // Size above the maximum is clamped: a record up to the clamped end is
    // accepted, one past it fails; a smaller size then closes each block
    task automatic test_largest_size();
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'hFFFF_FFFF);
        block_q.delete();
        add_header(32'h1234_5678, 16'd65532, 8'd255, 8'd1);
        pad_block(270);
        send_block(block_q.size());
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd272);
        finish_block();
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'hFFFF_FFFF);
        block_q.delete();
        add_entry(32'h1234_5679, 8, 0, 1);
        add_header(32'h1234_567A, 16'd65532, 8'd4, 8'd1);
        send_block(block_q.size());
        write_reg(dbp_pkg::REG_BLOCK_SIZE, 32'd32);
        finish_block();
    endtask

    // Result receiver: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        dbp_pkg::result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
                report("unexpected result kind", result_ch.kind, 0);
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", result_ch.kind, want.kind);
                check_field("entry_inode", result_ch.entry_inode, want.entry_inode);
                check_field("entry_type", result_ch.entry_type, want.entry_type);
                check_field("entry_name_length", result_ch.entry_name_length,
                            want.entry_name_length);
                check_field("name_char", result_ch.name_char, want.name_char);
                check_field("name_position", result_ch.name_position, want.name_position);
                check_field("name_final", result_ch.name_final, want.name_final);
                check_field("block_good", result_ch.block_good, want.block_good);
                check_field("last_of_run", result_ch.last_of_run, want.last_of_run);
            end
        end
    end

    // Abort when no item moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 15;
        snk_idle_pct = 59;
        test_register_access();
        test_entry_kinds();
        test_format_errors();
        test_short_remainder();
        test_smallest_block();
        test_size_change_mid_block();
        test_random_blocks(150);

        src_idle_pct = 59;
        snk_idle_pct = 15;
        test_backpressure();
        test_random_blocks(150);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_largest_size();

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
